/* rtl/neighbor_type_mixing_metric_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef NEIGHBOR_TYPE_MIXING_METRIC_MACROS_SVH
`define NEIGHBOR_TYPE_MIXING_METRIC_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define NTMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define NTMM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/ntmm_pkg.sv */
// Package for the neighbor type-mixing metric block: widths, codes, item types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ntmm_pkg;
  localparam int MaxTypes     = 4;
  localparam int MaxNeighbors = 256;
  localparam int CoordBits    = 24;
  localparam int CntW         = $clog2(MaxNeighbors + 1);
  localparam int TypeIdxW     = (MaxTypes > 1) ? $clog2(MaxTypes) : 1;

  typedef enum logic [1:0] {
    REG_CUT_SQ    = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_TYPE_FRAC = 2'd2,
    REG_NUM_TYPES = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CoordBits-1:0] center_x;
    logic [CoordBits-1:0] center_y;
    logic [CoordBits-1:0] center_z;
    logic [CoordBits-1:0] nbr_x;
    logic [CoordBits-1:0] nbr_y;
    logic [CoordBits-1:0] nbr_z;
    logic [2:0]           nbr_type;
    logic                 has_neighbor;
    logic                 last_of_atom;
    logic                 in_group;
  } in_item_t;

  typedef struct packed {
    logic [31:0] phase_value;
    logic        above_threshold;
    logic        zero_neighbors;
    logic        group_member;
    logic [47:0] total_sum;
    logic [31:0] count_above;
  } out_item_t;

  typedef struct packed {
    logic [63:0] cfg_data;
    logic [63:0] cfg_index;
  } cfg_req_t;
endpackage
`default_nettype wire

/* rtl/ntmm_if.sv */
// Valid/ready channel interfaces for items and configuration writes.
// Depends on ntmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ntmm_in_if import ntmm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ntmm_out_if import ntmm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ntmm_cfg_if import ntmm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [63:0] index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/ntmm_divider.sv */
// Restoring radix-2 divider, one quotient bit per cycle (17-bit quotient).
// Depends on ntmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ntmm_divider import ntmm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [CntW+16-1:0]  dividend_i,
  input  wire logic [CntW-1:0]     divisor_i,
  output logic                     done_o,
  output logic [16:0]              quotient_o
);
  localparam int NumW = CntW + 16;
  localparam int StepW = $clog2(NumW + 1);

  logic [NumW-1:0]  num_q;
  logic [CntW:0]    rem_q;
  logic [CntW-1:0]  den_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic [CntW:0]    trial;
  logic [CntW:0]    shifted;

  // Shift one dividend bit into the remainder and try a subtract
  assign shifted = {rem_q[CntW-1:0], num_q[NumW-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      step_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        num_q  <= dividend_i;
        den_q  <= divisor_i;
        rem_q  <= '0;
        step_q <= StepW'(NumW);
      end else if (busy_q) begin
        if (!trial[CntW]) rem_q <= trial;
        else rem_q <= shifted;
        num_q  <= {num_q[NumW-2:0], ~trial[CntW]};
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assign quotient_o = num_q[16:0];
endmodule
`default_nettype wire

/* rtl/ntmm_accum.sv */
// Per-atom neighbor counter: squared distance via one shared 25x25 multiplier.
// Depends on ntmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ntmm_accum import ntmm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire in_item_t            item_i,
  input  wire logic [51:0]         cut_sq_i,
  input  wire logic                clear_i,
  output logic                     done_o,
  output logic [CntW-1:0]          total_o,
  output logic [MaxTypes-1:0][CntW-1:0] counts_o
);
  typedef enum logic [1:0] {ACC_IDLE, ACC_MUL, ACC_LAST} acc_state_e;

  acc_state_e        state_q;
  logic [1:0]        axis_q;
  logic [64:0]       dist_q;
  logic [CoordBits:0] diff;
  logic [CoordBits:0] mag;
  logic [2*CoordBits+1:0] prod;
  logic [CoordBits-1:0] ca, nb;
  logic [65:0]       sum_next;
  logic [2:0]        ty;

  // Select one axis per cycle for the shared multiplier
  always_comb begin
    unique case (axis_q)
      2'd0:    begin ca = item_i.center_x; nb = item_i.nbr_x; end
      2'd1:    begin ca = item_i.center_y; nb = item_i.nbr_y; end
      default: begin ca = item_i.center_z; nb = item_i.nbr_z; end
    endcase
    diff = {ca[CoordBits-1], ca} - {nb[CoordBits-1], nb};
    mag  = diff[CoordBits] ? -diff : diff;
    prod = mag * mag;
    sum_next = {1'b0, dist_q} + 66'(prod);
  end

  assign ty = item_i.nbr_type;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ACC_IDLE;
      done_o   <= 1'b0;
      total_o  <= '0;
      counts_o <= '0;
      axis_q   <= '0;
      dist_q   <= '0;
    end else begin
      done_o <= 1'b0;
      if (clear_i) begin
        total_o  <= '0;
        counts_o <= '0;
      end
      unique case (state_q)
        ACC_IDLE: begin
          if (start_i) begin
            axis_q  <= '0;
            dist_q  <= '0;
            state_q <= item_i.has_neighbor ? ACC_MUL : ACC_LAST;
          end
        end
        ACC_MUL: begin
          dist_q <= sum_next[64:0];
          axis_q <= axis_q + 1'b1;
          if (axis_q == 2'd2) state_q <= ACC_LAST;
        end
        ACC_LAST: begin
          // Count when the item has a neighbor inside the cutoff
          if (item_i.has_neighbor && dist_q < 65'(cut_sq_i)) begin
            if (total_o < CntW'(MaxNeighbors)) total_o <= total_o + 1'b1;
            if (ty >= 3'd1 && ty <= 3'(MaxTypes)) begin
              if (counts_o[TypeIdxW'(ty - 3'd1)] < CntW'(MaxNeighbors))
                counts_o[TypeIdxW'(ty - 3'd1)] <= counts_o[TypeIdxW'(ty - 3'd1)] + 1'b1;
            end
          end
          done_o  <= 1'b1;
          state_q <= ACC_IDLE;
        end
        default: state_q <= ACC_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/neighbor_type_mixing_metric.sv */
// Top level of the neighbor type-mixing metric block.
// Depends on ntmm_pkg, ntmm_if, ntmm_accum and ntmm_divider.
//
// Usage: requests arrive on in_if, one neighbor per request, the centre position
// repeated each time. Configuration writes come on cfg_if (index, data); the user
// must make them only while the block is idle, as the block itself does not
// enforce this. A request marked last_of_atom produces one result on out_if;
// other requests produce none. Sequence: a neighbor request goes from accept to
// the next accept through accept, accumulator start, one multiply step per axis
// on the shared squaring multiplier, one compare and one handoff; an empty
// request skips the multiply. A last request of a group atom then takes, per
// type in use, one pass of the shared bit-serial divider (load, the quotient
// bits in turn, done) plus a squaring step, then one rounding and one output
// step, after which the next request is taken. With no counted neighbor the
// divider is skipped; a non-member atom or num_types of zero goes straight to
// rounding and output.
// Reset clears all counts, running totals and configuration to their defaults.
// A result is held in the output register while the receiver stalls; requests
// keep flowing meanwhile, and the next result waits until that register is taken.
`timescale 1ns / 1ps
`default_nettype none
module neighbor_type_mixing_metric import ntmm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ntmm_in_if.sink   in_if,
  ntmm_cfg_if.sink  cfg_if,
  ntmm_out_if.source out_if
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_ACC, ST_DIV, ST_SQ, ST_ROUND, ST_OUT
  } state_e;

  state_e        state_q;
  in_item_t      item_q;
  logic [51:0]   cut_sq_q;
  logic [31:0]   threshold_q;
  logic [63:0]   frac_q;
  logic [2:0]    num_types_q;
  logic [47:0]   run_sum_q;
  logic [31:0]   run_above_q;
  logic [TypeIdxW:0] t_q;
  logic [TypeIdxW:0] nt_lim;
  logic [34:0]   sum_q;
  logic [16:0]   loc_q;
  logic          acc_start_q, div_start_q, clear_q;
  logic          acc_done, div_done;
  logic [CntW-1:0] total;
  logic [MaxTypes-1:0][CntW-1:0] counts;
  logic [16:0]   quot;
  logic [15:0]   glob;
  logic [17:0]   dlt;
  logic [16:0]   dmag;
  logic [33:0]   dsq;
  logic [33:0]   rnd;
  logic [31:0]   metric;
  logic [48:0]   sum_ext;
  out_item_t     out_q;
  logic          out_valid_q;

  ntmm_accum u_accum (
    .clk_i, .rst_ni, .start_i(acc_start_q), .item_i(item_q), .cut_sq_i(cut_sq_q),
    .clear_i(clear_q), .done_o(acc_done), .total_o(total), .counts_o(counts)
  );

  ntmm_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start_q),
    .dividend_i({counts[t_q[TypeIdxW-1:0]], 16'd0} + (CntW+16)'(total >> 1)),
    .divisor_i(total), .done_o(div_done), .quotient_o(quot)
  );

  assign nt_lim = (num_types_q > 3'(MaxTypes)) ? (TypeIdxW+1)'(MaxTypes)
                                               : (TypeIdxW+1)'(num_types_q);
  assign glob   = frac_q[16*t_q[TypeIdxW-1:0] +: 16];
  assign dlt    = {1'b0, loc_q} - {2'b0, glob};
  assign dmag   = dlt[17] ? 17'(-dlt) : dlt[16:0];
  assign dsq    = dmag * dmag;
  assign rnd    = 34'((sum_q + 35'd2) >> 2);
  assign metric = (rnd > 34'hFFFFFFFF) ? 32'hFFFFFFFF : rnd[31:0];
  assign sum_ext = {1'b0, run_sum_q} + 49'(metric);

  assign in_if.ready  = (state_q == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_sq_q    <= '0;
      threshold_q <= 32'hFFFFFFFF;
      frac_q      <= '0;
      num_types_q <= 3'd2;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == 64'(REG_CUT_SQ))    cut_sq_q    <= cfg_if.data[51:0];
      if (cfg_if.index == 64'(REG_THRESHOLD)) threshold_q <= cfg_if.data[31:0];
      if (cfg_if.index == 64'(REG_TYPE_FRAC)) frac_q      <= cfg_if.data;
      if (cfg_if.index == 64'(REG_NUM_TYPES)) num_types_q <= cfg_if.data[2:0];
    end
  end

  // Sequencer over the accumulator and the shared divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_start_q <= 1'b0;
      div_start_q <= 1'b0;
      clear_q     <= 1'b0;
      out_valid_q <= 1'b0;
      run_sum_q   <= '0;
      run_above_q <= '0;
      t_q         <= '0;
      sum_q       <= '0;
      loc_q       <= '0;
    end else begin
      acc_start_q <= 1'b0;
      div_start_q <= 1'b0;
      clear_q     <= 1'b0;
      if (out_valid_q && out_if.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_if.valid && in_if.ready) begin
            item_q      <= in_if.data;
            acc_start_q <= 1'b1;
            state_q     <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (acc_done) begin
            t_q   <= '0;
            sum_q <= '0;
            if (!item_q.last_of_atom) state_q <= ST_IDLE;
            else if (!item_q.in_group) state_q <= ST_ROUND;
            else if (nt_lim == '0) state_q <= ST_ROUND;
            else if (total == '0) begin
              loc_q   <= '0;
              state_q <= ST_SQ;
            end else begin
              div_start_q <= 1'b1;
              state_q     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            loc_q   <= quot;
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          // Add this type's squared deviation, then advance to the next type
          sum_q <= sum_q + 35'(dsq);
          t_q   <= t_q + 1'b1;
          if (t_q + 1'b1 == nt_lim) state_q <= ST_ROUND;
          else if (total == '0) loc_q <= '0;
          else begin
            div_start_q <= 1'b1;
            state_q     <= ST_DIV;
          end
        end
        ST_ROUND: begin
          // Hold until the previous result has left the output register
          if (!out_valid_q || out_if.ready) begin
            if (item_q.in_group) begin
              run_sum_q <= sum_ext[48] ? 48'hFFFFFFFFFFFF : sum_ext[47:0];
              if (metric > threshold_q && run_above_q != 32'hFFFFFFFF)
                run_above_q <= run_above_q + 1'b1;
            end
            out_q.phase_value     <= item_q.in_group ? metric : '0;
            out_q.above_threshold <= item_q.in_group && (metric > threshold_q);
            out_q.zero_neighbors  <= item_q.in_group && (total == '0);
            state_q               <= ST_OUT;
          end
        end
        ST_OUT: begin
          out_q.group_member <= item_q.in_group;
          out_q.total_sum    <= run_sum_q;
          out_q.count_above  <= run_above_q;
          out_valid_q        <= 1'b1;
          clear_q            <= 1'b1;
          state_q            <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/ntmm_checker.sv */
// Port-level checker for the neighbor type-mixing metric block, with bind.
// Depends on ntmm_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "neighbor_type_mixing_metric_macros.svh"
module ntmm_checker import ntmm_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);
  `NTMM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_data))
  `NTMM_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid && in_ready, !in_ready)
  `NTMM_ASSERT_NXT(a_drop_after_take, clk_i, rst_ni, out_valid && out_ready, !out_valid)
  `NTMM_ASSERT_IMP(a_nonmember_zero, clk_i, rst_ni, out_valid && !out_data.group_member, out_data.phase_value == '0 && !out_data.above_threshold)
endmodule

bind neighbor_type_mixing_metric ntmm_checker u_checker (
  .clk_i, .rst_ni, .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the neighbor type-mixing metric block.
// Depends on ntmm_pkg, ntmm_if and the neighbor_type_mixing_metric RTL.
`timescale 1ns / 1ps
module testbench;
  import ntmm_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ntmm_in_if  in_if ();
  ntmm_cfg_if cfg_if ();
  ntmm_out_if out_if ();

  neighbor_type_mixing_metric i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .out_if (out_if)
  );

  // Run the clock: 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow configuration and per-atom tallies
  logic [51:0] cut_sq_q;
  logic [31:0] thresh_q;
  logic [63:0] frac_q;
  logic [2:0]  ntypes_q;
  int unsigned tally[MaxTypes];
  int unsigned nbr_tally;
  logic [47:0] sum_q;
  logic [31:0] above_q;

  in_item_t  pending_q[$];
  out_item_t metric_q[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_off = 0;
  bit        stim_done = 1'b0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
    errors++;
  endtask

  function automatic logic [63:0] sq_sat(input logic [23:0] a, input logic [23:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    if (d < 0) d = -d;
    return 64'(d) * 64'(d);
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // Advance the predictor by one accepted request
  task automatic predict_metric(input in_item_t it);
    logic [63:0] sq_total, glob, loc, sum, r, diff;
    int nt;
    out_item_t o;
    if (it.has_neighbor) begin
      sq_total = sq_sat(it.center_x, it.nbr_x);
      sq_total = add_sat(sq_total, sq_sat(it.center_y, it.nbr_y));
      sq_total = add_sat(sq_total, sq_sat(it.center_z, it.nbr_z));
      if (sq_total < {12'b0, cut_sq_q}) begin
        if (nbr_tally < MaxNeighbors) nbr_tally++;
        if (it.nbr_type >= 1 && it.nbr_type <= MaxTypes)
          if (tally[it.nbr_type-1] < MaxNeighbors) tally[it.nbr_type-1]++;
      end
    end
    if (!it.last_of_atom) return;
    o = '0;
    o.group_member = it.in_group;
    if (it.in_group) begin
      nt = (ntypes_q > MaxTypes) ? MaxTypes : ntypes_q;
      sum = 0;
      for (int t = 0; t < nt; t++) begin
        glob = (frac_q >> (16 * t)) & 64'hFFFF;
        loc = 0;
        if (nbr_tally != 0)
          loc = (64'(tally[t]) * 65536 + nbr_tally / 2) / nbr_tally;
        diff = (loc > glob) ? loc - glob : glob - loc;
        sum += diff * diff;
      end
      r = (sum + 2) >> 2;
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      o.phase_value = r[31:0];
      o.zero_neighbors = (nbr_tally == 0);
      o.above_threshold = (r[31:0] > thresh_q);
      sum = {16'b0, sum_q} + r;
      sum_q = (sum > 64'hFFFF_FFFF_FFFF) ? '1 : sum[47:0];
      if (o.above_threshold && above_q != '1) above_q++;
    end
    o.total_sum = sum_q;
    o.count_above = above_q;
    for (int t = 0; t < MaxTypes; t++) tally[t] = 0;
    nbr_tally = 0;
    metric_q.push_back(o);
  endtask

  // Drive requests from the pending queue with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_metric(in_if.data);
        void'(pending_q.pop_front());
      end
      if ((!in_if.valid || in_if.ready)) begin
        if (pending_q.size() > ((in_if.valid && in_if.ready) ? 0 : 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.data <= pending_q[0];
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Count down a long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // Check results and stall the receiver at random
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_o;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (metric_q.size() == 0) begin
          report("unexpected result", out_if.data.phase_value, 0);
        end else begin
          exp_o = metric_q.pop_front();
          if (out_if.data.phase_value !== exp_o.phase_value)
            report("phase_value", out_if.data.phase_value, exp_o.phase_value);
          if (out_if.data.above_threshold !== exp_o.above_threshold)
            report("above_threshold", out_if.data.above_threshold, exp_o.above_threshold);
          if (out_if.data.zero_neighbors !== exp_o.zero_neighbors)
            report("zero_neighbors", out_if.data.zero_neighbors, exp_o.zero_neighbors);
          if (out_if.data.group_member !== exp_o.group_member)
            report("group_member", out_if.data.group_member, exp_o.group_member);
          if (out_if.data.total_sum !== exp_o.total_sum)
            report("total_sum", out_if.data.total_sum, exp_o.total_sum);
          if (out_if.data.count_above !== exp_o.count_above)
            report("count_above", out_if.data.count_above, exp_o.count_above);
        end
      end
      out_if.ready <= (hold_off == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Write one register and mirror it in the predictor
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    cfg_if.index <= 64'(idx);
    cfg_if.data <= value;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_CUT_SQ:    cut_sq_q = value[51:0];
      REG_THRESHOLD: thresh_q = value[31:0];
      REG_TYPE_FRAC: frac_q = value;
      REG_NUM_TYPES: ntypes_q = value[2:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Wait until every request is taken and every result has arrived
  task automatic drain();
    while (pending_q.size() != 0 || in_if.valid || metric_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rnd_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($signed(24'($urandom_range(0, 8192))) - 24'sd4096);
      2: return $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
      default: return 24'($urandom_range(0, 16384));
    endcase
  endfunction

  // Queue one atom: a centre plus a short neighbor list
  task automatic queue_atom(input int n, input bit spread);
    in_item_t it;
    logic [23:0] cx, cy, cz;
    cx = rnd_coord(); cy = rnd_coord(); cz = rnd_coord();
    it = '0;
    for (int k = 0; k < n; k++) begin
      it.center_x = cx; it.center_y = cy; it.center_z = cz;
      if (spread) begin
        it.nbr_x = rnd_coord(); it.nbr_y = rnd_coord(); it.nbr_z = rnd_coord();
      end else begin
        it.nbr_x = cx + 24'($urandom_range(0, 8000)) - 24'd4000;
        it.nbr_y = cy + 24'($urandom_range(0, 8000)) - 24'd4000;
        it.nbr_z = cz + 24'($urandom_range(0, 8000)) - 24'd4000;
      end
      it.nbr_type = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
      it.has_neighbor = ($urandom_range(15) != 0);
      it.last_of_atom = (k == n - 1);
      it.in_group = ($urandom_range(7) != 0);
      pending_q.push_back(it);
    end
  endtask

  function automatic logic [63:0] rnd_fracs();
    return {$urandom(), $urandom()} & {4{16'($urandom_range(1) ? 16'hFFFF : 16'h3FFF)}};
  endfunction

  // Stimulus and phases
  initial begin
    in_item_t it;
    int sent;
    cut_sq_q = '0; thresh_q = '1; frac_q = '0; ntypes_q = 3'd2;
    sum_q = '0; above_q = '0; nbr_tally = 0;
    for (int t = 0; t < MaxTypes; t++) tally[t] = 0;
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset config, empty atom, extremes, out-of-range types
    it = '0; it.last_of_atom = 1'b1; it.in_group = 1'b1;
    pending_q.push_back(it);
    it.in_group = 1'b0; pending_q.push_back(it);
    drain();
    write_reg(REG_CUT_SQ, 64'hF_FFFF_FFFF_FFFF);
    write_reg(REG_THRESHOLD, 64'd0);
    write_reg(REG_TYPE_FRAC, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_NUM_TYPES, 64'd7);
    for (int k = 0; k < 8; k++) begin
      it = '0;
      it.center_x = (k[0]) ? 24'h800000 : 24'h7FFFFF;
      it.center_y = 24'h800000; it.center_z = 24'h7FFFFF;
      it.nbr_x = (k[0]) ? 24'h7FFFFF : 24'h800000;
      it.nbr_y = 24'h7FFFFF; it.nbr_z = (k[1]) ? 24'h800000 : 24'h7FFFFF;
      it.nbr_type = 3'(k); it.has_neighbor = 1'b1;
      it.last_of_atom = (k == 7); it.in_group = 1'b1;
      pending_q.push_back(it);
    end
    drain();
    write_reg(REG_NUM_TYPES, 64'd0);
    queue_atom(3, 0);
    drain();
    write_reg(REG_NUM_TYPES, 64'd1);
    write_reg(REG_TYPE_FRAC, 64'd0);
    queue_atom(4, 0);
    // Overflow the counts beyond the neighbor limit
    it = '0; it.has_neighbor = 1'b1; it.nbr_type = 3'd1; it.in_group = 1'b1;
    for (int k = 0; k < 300; k++) begin
      it.last_of_atom = (k == 299);
      pending_q.push_back(it);
    end
    drain();

    // Random phases: no idling, sender idle, receiver stall, both
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      write_reg(REG_CUT_SQ, (ph == 7) ? 64'd0 : 64'($urandom_range(1, 1 << 26)) << ph);
      write_reg(REG_THRESHOLD, (ph == 5) ? 64'hFFFF_FFFF : 64'($urandom_range(0, 1 << 30)));
      write_reg(REG_TYPE_FRAC, rnd_fracs());
      write_reg(REG_NUM_TYPES, 64'($urandom_range(0, 7)));
      if (ph == 2) hold_off = 400;
      while (sent < (ph + 1) * 125) begin
        int n;
        n = $urandom_range(1, 6);
        queue_atom(n, $urandom_range(4) == 0);
        sent += n;
        if ($urandom_range(19) == 0) begin
          it = '0; it.center_x = 24'($urandom); it.has_neighbor = $urandom_range(1);
          pending_q.push_back(it);
          sent++;
        end
      end
      drain();
    end
    stim_done = 1'b1;
  end

  // Finish once the stimulus is spent and the block is quiet
  initial begin
    wait (stim_done);
    repeat (100) @(posedge clk_i);
    if (pending_q.size() == 0 && metric_q.size() == 0 && errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl
rtl/ntmm_pkg.sv
rtl/ntmm_if.sv
rtl/ntmm_divider.sv
rtl/ntmm_accum.sv
rtl/neighbor_type_mixing_metric.sv
rtl/ntmm_checker.sv
tb/sv/testbench.sv
